@@ hdl/mvna_pkg.sv @@
// ---------------------------------------------------------------------------
// Mesh vertex normal accumulator package
// Shared command codes, datapath operation codes and the control/status
// structures exchanged between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package mvna_pkg;

    localparam int ADDR_W = 12;
    localparam int POS_W  = 20;
    localparam int NORM_W = 16;
    localparam int SUM_W  = 64;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_WRITE   = 2'd0;
    localparam cmd_t CMD_PUSH    = 2'd1;
    localparam cmd_t CMD_READ    = 2'd2;
    localparam cmd_t CMD_RESTART = 2'd3;

    typedef logic [4:0] dp_op_t;
    localparam dp_op_t OP_NOP       = 5'd0;
    localparam dp_op_t OP_CLR       = 5'd1;
    localparam dp_op_t OP_POS_WR    = 5'd2;
    localparam dp_op_t OP_RESTART   = 5'd3;
    localparam dp_op_t OP_STREAM    = 5'd4;
    localparam dp_op_t OP_POS_RD    = 5'd5;
    localparam dp_op_t OP_EDGE      = 5'd6;
    localparam dp_op_t OP_MUL       = 5'd7;
    localparam dp_op_t OP_SUM_RD    = 5'd8;
    localparam dp_op_t OP_SUM_ACC   = 5'd9;
    localparam dp_op_t OP_MAG       = 5'd10;
    localparam dp_op_t OP_SHIFT     = 5'd11;
    localparam dp_op_t OP_ZERO_RES  = 5'd12;
    localparam dp_op_t OP_SQ        = 5'd13;
    localparam dp_op_t OP_SQRT_INIT = 5'd14;
    localparam dp_op_t OP_SQRT_STEP = 5'd15;
    localparam dp_op_t OP_DIV_INIT  = 5'd16;
    localparam dp_op_t OP_DIV_STEP  = 5'd17;
    localparam dp_op_t OP_DIV_STORE = 5'd18;
    localparam dp_op_t OP_OUT_LOAD  = 5'd19;

    // Selector value that makes a sum read use the item's own address.
    localparam logic [2:0] SEL_ADDR = 3'd3;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] sel;
        logic       capture;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic addr_ok;
        logic face_close;
        logic face_ok;
        logic clr_last;
        logic m_zero;
        logic big;
        logic sqrt_last;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/mvna_ctrl.sv @@
// ---------------------------------------------------------------------------
// Mesh vertex normal accumulator controller
// Sequences the datapath for vertex writes, face accumulation and normal
// reads, and owns the input and output handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module mvna_ctrl
    import mvna_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t st,
    output dp_cmd_t       dcmd
);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISPATCH = 5'd2;
    localparam logic [4:0] S_RDP      = 5'd3;
    localparam logic [4:0] S_RDWAIT   = 5'd4;
    localparam logic [4:0] S_EDGE     = 5'd5;
    localparam logic [4:0] S_MUL      = 5'd6;
    localparam logic [4:0] S_MDRAIN   = 5'd7;
    localparam logic [4:0] S_SRD      = 5'd8;
    localparam logic [4:0] S_SWR      = 5'd9;
    localparam logic [4:0] S_NMAG     = 5'd10;
    localparam logic [4:0] S_NCHK     = 5'd11;
    localparam logic [4:0] S_NSHIFT   = 5'd12;
    localparam logic [4:0] S_NSQ      = 5'd13;
    localparam logic [4:0] S_NSQDRAIN = 5'd14;
    localparam logic [4:0] S_SQINIT   = 5'd15;
    localparam logic [4:0] S_SQRT     = 5'd16;
    localparam logic [4:0] S_DIVI     = 5'd17;
    localparam logic [4:0] S_DIVS     = 5'd18;
    localparam logic [4:0] S_DIVW     = 5'd19;
    localparam logic [4:0] S_OUT      = 5'd20;

    logic [4:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dcmd.op        = OP_NOP;
        dcmd.sel       = 3'd0;
        dcmd.capture   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                dcmd.op = OP_CLR;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                dcmd.capture = in_valid;
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cnt_next = '0;
                unique case (st.cmd)
                    CMD_WRITE:
                    begin
                        dcmd.op    = OP_POS_WR;
                        state_next = S_IDLE;
                    end
                    CMD_RESTART:
                    begin
                        dcmd.op    = OP_RESTART;
                        state_next = S_IDLE;
                    end
                    CMD_PUSH:
                    begin
                        dcmd.op    = OP_STREAM;
                        state_next = (st.face_close && st.face_ok) ? S_RDP : S_IDLE;
                    end
                    CMD_READ:
                    begin
                        if (st.addr_ok)
                        begin
                            dcmd.op    = OP_SUM_RD;
                            dcmd.sel   = SEL_ADDR;
                            state_next = S_NMAG;
                        end
                        else
                        begin
                            dcmd.op    = OP_ZERO_RES;
                            state_next = S_OUT;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_RDP:
            begin
                dcmd.op  = OP_POS_RD;
                dcmd.sel = cnt_reg[2:0];
                if (cnt_reg == 4'd2)
                    state_next = S_RDWAIT;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_RDWAIT: state_next = S_EDGE;
            S_EDGE:
            begin
                dcmd.op    = OP_EDGE;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                dcmd.op  = OP_MUL;
                dcmd.sel = cnt_reg[2:0];
                if (cnt_reg == 4'd5)
                begin
                    cnt_next   = '0;
                    state_next = S_MDRAIN;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_MDRAIN: state_next = S_SRD;
            S_SRD:
            begin
                dcmd.op    = OP_SUM_RD;
                dcmd.sel   = cnt_reg[2:0];
                state_next = S_SWR;
            end
            S_SWR:
            begin
                dcmd.op  = OP_SUM_ACC;
                dcmd.sel = cnt_reg[2:0];
                if (cnt_reg == 4'd2)
                    state_next = S_IDLE;
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_SRD;
                end
            end
            S_NMAG:
            begin
                dcmd.op    = OP_MAG;
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                if (st.m_zero)
                begin
                    dcmd.op    = OP_ZERO_RES;
                    state_next = S_OUT;
                end
                else
                    state_next = S_NSHIFT;
            end
            S_NSHIFT:
            begin
                cnt_next = '0;
                if (st.big)
                    dcmd.op = OP_SHIFT;
                else
                    state_next = S_NSQ;
            end
            S_NSQ:
            begin
                dcmd.op  = OP_SQ;
                dcmd.sel = cnt_reg[2:0];
                if (cnt_reg == 4'd2)
                    state_next = S_NSQDRAIN;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_NSQDRAIN: state_next = S_SQINIT;
            S_SQINIT:
            begin
                dcmd.op    = OP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                dcmd.op   = OP_SQRT_STEP;
                axis_next = '0;
                if (st.sqrt_last)
                    state_next = S_DIVI;
            end
            S_DIVI:
            begin
                dcmd.op    = OP_DIV_INIT;
                dcmd.sel   = {1'b0, axis_reg};
                cnt_next   = '0;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                dcmd.op = OP_DIV_STEP;
                if (cnt_reg == 4'd15)
                    state_next = S_DIVW;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_DIVW:
            begin
                dcmd.op  = OP_DIV_STORE;
                dcmd.sel = {1'b0, axis_reg};
                if (axis_reg == 2'd2)
                    state_next = S_OUT;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DIVI;
                end
            end
            S_OUT:
            begin
                // The previous result must be taken before this one replaces it.
                if (!out_valid_reg || out_ready)
                begin
                    dcmd.op        = OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/mvna_dp.sv @@
// ---------------------------------------------------------------------------
// Mesh vertex normal accumulator datapath
// Position and sum memories, index stream state, the shared multiplier,
// the square root and divider iterations, and the result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module mvna_dp
    import mvna_pkg::*;
#(
    parameter int MAX_VERTS = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_wr_data,
    input  wire logic [1:0]               cmd,
    input  wire logic [ADDR_W-1:0]        vertex_addr,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic signed [POS_W-1:0]  pos_z,
    input  wire logic [ADDR_W-1:0]        index_value,
    input  wire dp_cmd_t                  dcmd,
    output dp_stat_t                      st,
    output logic signed [NORM_W-1:0]      normal_x,
    output logic signed [NORM_W-1:0]      normal_y,
    output logic signed [NORM_W-1:0]      normal_z,
    output logic                          zero_normal
);

    localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;

    // Captured item.
    cmd_t                     cmd_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [ADDR_W-1:0]        idx_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg, pz_reg;

    // Control state.
    logic                     mode_reg;
    logic [ADDR_W-1:0]        prior_a_reg, prior_b_reg;
    logic [1:0]               phase_reg;
    logic                     odd_reg;
    logic [AW-1:0]            clr_cnt_reg;
    logic                     pos_pend_reg;
    logic [1:0]               pos_sel_reg;
    logic [1:0]               acc_op_reg;
    logic [2:0]               acc_sel_reg;

    // Face and arithmetic payload.
    logic [AW-1:0]            v_reg [3];
    logic signed [POS_W-1:0]  p_reg [3][3];
    logic signed [POS_W:0]    e1_reg [3];
    logic signed [POS_W:0]    e2_reg [3];
    logic signed [61:0]       prod_reg;
    logic signed [42:0]       n_reg [3];
    logic [63:0]              m_reg [3];
    logic                     neg_reg [3];
    logic [61:0]              sq_reg;
    logic [63:0]              rn_reg, root_reg, bit_reg;
    logic [31:0]              len_reg;
    logic [32:0]              rem_reg;
    logic [15:0]              dvd_reg, q_reg;
    logic signed [NORM_W-1:0] res_reg [3];
    logic                     res_zero_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic                     nzero_reg;

    // Memories.
    logic [3*POS_W-1:0]       pos_mem [MAX_VERTS];
    logic [3*POS_W-1:0]       pos_rdata;
    logic [3*SUM_W-1:0]       sum_mem [MAX_VERTS];
    logic [3*SUM_W-1:0]       sum_rdata;

    localparam int ACC_NONE  = 0;
    localparam int ACC_CROSS = 1;
    localparam int ACC_SQ    = 2;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic signed [42:0] b);
        logic [SUM_W-1:0] bx;
        logic [SUM_W-1:0] s;
        bx = SUM_W'(b);
        s  = a + bx;
        if (!a[SUM_W-1] && !bx[SUM_W-1] && s[SUM_W-1])
            return {1'b0, {(SUM_W-1){1'b1}}};
        if (a[SUM_W-1] && bx[SUM_W-1] && !s[SUM_W-1])
            return {1'b1, {(SUM_W-1){1'b0}}};
        return s;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Index stream: the face that the pending push would close.
    logic [ADDR_W-1:0] fa, fb;
    logic              swap;
    logic              addr_ok, face_ok;
    logic [AW-1:0]     addr_idx;
    logic [AW-1:0]     sum_addr;
    logic              sum_we, sum_re;
    logic [3*SUM_W-1:0] sum_wdata;
    logic [1:0]        vsel;

    assign swap    = mode_reg && odd_reg;
    assign fa      = swap ? prior_b_reg : prior_a_reg;
    assign fb      = swap ? prior_a_reg : prior_b_reg;
    assign addr_ok = (32'(addr_reg) < 32'(MAX_VERTS));
    assign face_ok = (32'(fa) < 32'(MAX_VERTS)) && (32'(fb) < 32'(MAX_VERTS))
                     && (32'(idx_reg) < 32'(MAX_VERTS));
    assign addr_idx = AW'(addr_reg);
    assign vsel     = dcmd.sel[1:0];

    always_comb
    begin
        st.cmd        = cmd_reg;
        st.addr_ok    = addr_ok;
        st.face_close = (phase_reg == 2'd2);
        st.face_ok    = face_ok;
        st.clr_last   = (32'(clr_cnt_reg) == 32'(MAX_VERTS - 1));
        st.m_zero     = (m_reg[0] == '0) && (m_reg[1] == '0) && (m_reg[2] == '0);
        st.big        = |(m_reg[0][63:30] | m_reg[1][63:30] | m_reg[2][63:30]);
        st.sqrt_last  = bit_reg[0];
    end

    // Sum memory port.
    always_comb
    begin
        sum_addr  = v_reg[vsel];
        sum_we    = 1'b0;
        sum_re    = 1'b0;
        sum_wdata = '0;
        unique case (dcmd.op)
            OP_CLR:
            begin
                sum_addr = clr_cnt_reg;
                sum_we   = 1'b1;
            end
            OP_POS_WR:
            begin
                sum_addr = addr_idx;
                sum_we   = addr_ok;
            end
            OP_SUM_RD:
            begin
                sum_re = 1'b1;
                if (dcmd.sel == SEL_ADDR)
                    sum_addr = addr_idx;
            end
            OP_SUM_ACC:
            begin
                sum_we    = 1'b1;
                sum_wdata = {sat_add(sum_rdata[3*SUM_W-1:2*SUM_W], n_reg[0]),
                             sat_add(sum_rdata[2*SUM_W-1:SUM_W], n_reg[1]),
                             sat_add(sum_rdata[SUM_W-1:0], n_reg[2])};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_addr] <= sum_wdata;
        if (sum_re)
            sum_rdata <= sum_mem[sum_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.op == OP_POS_WR && addr_ok)
            pos_mem[addr_idx] <= {px_reg, py_reg, pz_reg};
        if (dcmd.op == OP_POS_RD)
            pos_rdata <= pos_mem[v_reg[vsel]];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            prior_a_reg  <= '0;
            prior_b_reg  <= '0;
            phase_reg    <= '0;
            odd_reg      <= 1'b0;
            clr_cnt_reg  <= '0;
            pos_pend_reg <= 1'b0;
            pos_sel_reg  <= '0;
            acc_op_reg   <= 2'(ACC_NONE);
            acc_sel_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (dcmd.op == OP_CLR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (dcmd.op == OP_RESTART)
            begin
                phase_reg <= '0;
                odd_reg   <= 1'b0;
            end
            if (dcmd.op == OP_STREAM)
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        prior_a_reg <= idx_reg;
                        phase_reg   <= 2'd1;
                    end
                    2'd1:
                    begin
                        prior_b_reg <= idx_reg;
                        phase_reg   <= 2'd2;
                    end
                    default:
                    begin
                        if (!mode_reg)
                            phase_reg <= 2'd0;
                        else
                        begin
                            prior_a_reg <= prior_b_reg;
                            prior_b_reg <= idx_reg;
                            odd_reg     <= !odd_reg;
                        end
                    end
                endcase
            end
            pos_pend_reg <= (dcmd.op == OP_POS_RD);
            pos_sel_reg  <= vsel;
            acc_sel_reg  <= dcmd.sel;
            if (dcmd.op == OP_MUL)
                acc_op_reg <= 2'(ACC_CROSS);
            else if (dcmd.op == OP_SQ)
                acc_op_reg <= 2'(ACC_SQ);
            else
                acc_op_reg <= 2'(ACC_NONE);
        end
    end

    // Multiplier operand selection for the cross product and the squares.
    logic signed [30:0] mul_a, mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (dcmd.op == OP_SQ)
        begin
            mul_a = {1'b0, m_reg[vsel][29:0]};
            mul_b = {1'b0, m_reg[vsel][29:0]};
        end
        else
        begin
            unique case (dcmd.sel)
                3'd0:
                begin
                    mul_a = 31'(e1_reg[1]);
                    mul_b = 31'(e2_reg[2]);
                end
                3'd1:
                begin
                    mul_a = 31'(e1_reg[2]);
                    mul_b = 31'(e2_reg[1]);
                end
                3'd2:
                begin
                    mul_a = 31'(e1_reg[2]);
                    mul_b = 31'(e2_reg[0]);
                end
                3'd3:
                begin
                    mul_a = 31'(e1_reg[0]);
                    mul_b = 31'(e2_reg[2]);
                end
                3'd4:
                begin
                    mul_a = 31'(e1_reg[0]);
                    mul_b = 31'(e2_reg[1]);
                end
                3'd5:
                begin
                    mul_a = 31'(e1_reg[1]);
                    mul_b = 31'(e2_reg[0]);
                end
                default: ;
            endcase
        end
    end

    logic [63:0] sq_try;
    logic [32:0] div_try;
    logic [44:0] div_num;
    logic [15:0] q_clamp;

    assign sq_try  = root_reg + bit_reg;
    assign div_try = {rem_reg[31:0], dvd_reg[15]};
    // The root stays put through all three divisions, so the rounding term
    // is taken from it directly.
    assign div_num = (45'(m_reg[vsel][29:0]) << 14) + 45'(root_reg[31:1]);
    assign q_clamp = (q_reg > 16'd16384) ? 16'd16384 : q_reg;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (dcmd.capture)
        begin
            cmd_reg  <= cmd;
            addr_reg <= vertex_addr;
            idx_reg  <= index_value;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
        end

        if (dcmd.op == OP_STREAM && phase_reg == 2'd2)
        begin
            v_reg[0] <= AW'(fa);
            v_reg[1] <= AW'(fb);
            v_reg[2] <= AW'(idx_reg);
        end

        if (pos_pend_reg)
        begin
            p_reg[pos_sel_reg][0] <= pos_rdata[3*POS_W-1:2*POS_W];
            p_reg[pos_sel_reg][1] <= pos_rdata[2*POS_W-1:POS_W];
            p_reg[pos_sel_reg][2] <= pos_rdata[POS_W-1:0];
        end

        if (dcmd.op == OP_EDGE)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= (POS_W+1)'(p_reg[0][k]) - (POS_W+1)'(p_reg[1][k]);
                e2_reg[k] <= (POS_W+1)'(p_reg[0][k]) - (POS_W+1)'(p_reg[2][k]);
            end
        end

        if (dcmd.op == OP_MUL || dcmd.op == OP_SQ)
            prod_reg <= mul_a * mul_b;

        // Each cross term pair becomes one normal component.
        if (acc_op_reg == 2'(ACC_CROSS))
        begin
            if (!acc_sel_reg[0])
                n_reg[acc_sel_reg[2:1]] <= $signed(prod_reg[42:0]);
            else
                n_reg[acc_sel_reg[2:1]] <= n_reg[acc_sel_reg[2:1]]
                                           - $signed(prod_reg[42:0]);
        end
        else if (acc_op_reg == 2'(ACC_SQ))
        begin
            if (acc_sel_reg == 3'd0)
                sq_reg <= 62'(prod_reg);
            else
                sq_reg <= sq_reg + 62'(prod_reg);
        end

        if (dcmd.op == OP_MAG)
        begin
            m_reg[0]     <= mag(sum_rdata[3*SUM_W-1:2*SUM_W]);
            m_reg[1]     <= mag(sum_rdata[2*SUM_W-1:SUM_W]);
            m_reg[2]     <= mag(sum_rdata[SUM_W-1:0]);
            neg_reg[0]   <= sum_rdata[3*SUM_W-1];
            neg_reg[1]   <= sum_rdata[2*SUM_W-1];
            neg_reg[2]   <= sum_rdata[SUM_W-1];
            res_zero_reg <= 1'b0;
        end
        else if (dcmd.op == OP_SHIFT)
        begin
            for (int k = 0; k < 3; k++)
                m_reg[k] <= m_reg[k] >> 1;
        end

        if (dcmd.op == OP_SQRT_INIT)
        begin
            rn_reg   <= 64'(sq_reg);
            root_reg <= '0;
            bit_reg  <= 64'd1 << 62;
        end
        else if (dcmd.op == OP_SQRT_STEP)
        begin
            if (rn_reg >= sq_try)
            begin
                rn_reg   <= rn_reg - sq_try;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end

        if (dcmd.op == OP_DIV_INIT)
        begin
            if (vsel == 2'd0)
                len_reg <= root_reg[31:0];
            rem_reg <= 33'(div_num[44:16]);
            dvd_reg <= div_num[15:0];
            q_reg   <= '0;
        end
        else if (dcmd.op == OP_DIV_STEP)
        begin
            if (div_try >= {1'b0, len_reg})
            begin
                rem_reg <= div_try - {1'b0, len_reg};
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_try;
                q_reg   <= {q_reg[14:0], 1'b0};
            end
            dvd_reg <= {dvd_reg[14:0], 1'b0};
        end

        if (dcmd.op == OP_DIV_STORE)
            res_reg[vsel] <= neg_reg[vsel] ? -$signed(q_clamp) : $signed(q_clamp);

        if (dcmd.op == OP_ZERO_RES)
        begin
            res_reg[0]   <= '0;
            res_reg[1]   <= '0;
            res_reg[2]   <= '0;
            res_zero_reg <= 1'b1;
        end

        if (dcmd.op == OP_OUT_LOAD)
        begin
            nx_reg    <= res_reg[0];
            ny_reg    <= res_reg[1];
            nz_reg    <= res_reg[2];
            nzero_reg <= res_zero_reg;
        end
    end

    assign normal_x    = nx_reg;
    assign normal_y    = ny_reg;
    assign normal_z    = nz_reg;
    assign zero_normal = nzero_reg;

endmodule

`default_nettype wire

@@ hdl/mesh_vertex_normal_accumulator_core.sv @@
// ---------------------------------------------------------------------------
// Mesh vertex normal accumulator
// Stores vertex positions, accumulates face normals from an index stream
// into per-vertex saturating sums, and returns normalized vertex normals.
// ---------------------------------------------------------------------------
//  Channel   Signals                          Direction  Moves
//  input     in_valid / in_ready + fields     in         one command item
//  output    out_valid / out_ready + fields   out        one normal item
//  config    cfg_wr_en / cfg_wr_data          in         mode register
//
//  A push that closes a face reads its three positions, forms the edges,
//  computes the six cross terms on the shared multiplier and adds the
//  normal into the sums of its three vertices in turn. A normal read
//  runs a shift search, a square root and three divisions; a zero sum or
//  an address outside the table ends early with a zero result.
//  After reset the sum memory is cleared, one entry a cycle, before the
//  first item is taken. A finished read result waits in the output
//  register; input items keep being taken meanwhile, and a later read
//  holds in its last cycle until that result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_normal_accumulator_core
    import mvna_pkg::*;
#(
    parameter int MAX_VERTS = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               cmd,
    input  wire logic [ADDR_W-1:0]        vertex_addr,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic signed [POS_W-1:0]  pos_z,
    input  wire logic [ADDR_W-1:0]        index_value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [NORM_W-1:0]      normal_x,
    output logic signed [NORM_W-1:0]      normal_y,
    output logic signed [NORM_W-1:0]      normal_z,
    output logic                          zero_normal
);

    dp_cmd_t  dcmd;
    dp_stat_t st;

    mvna_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .dcmd      (dcmd)
    );

    mvna_dp #(
        .MAX_VERTS (MAX_VERTS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .vertex_addr (vertex_addr),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .index_value (index_value),
        .dcmd        (dcmd),
        .st          (st),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .zero_normal (zero_normal)
    );

endmodule

`default_nettype wire

@@ hdl/mvna_checker.sv @@
// ---------------------------------------------------------------------------
// Mesh vertex normal accumulator checker
// Port-level assertions on result items, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mvna_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] normal_x,
    input wire logic signed [15:0] normal_y,
    input wire logic signed [15:0] normal_z,
    input wire logic               zero_normal
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_normal |-> normal_x == 16'sd0 && normal_y == 16'sd0
                                     && normal_z == 16'sd0)
        else $error("zero flag with nonzero normal");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
                      && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
                      && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
        else $error("normal component outside unit range");

    // A new result comes only out of a read in progress, never from idle.
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind mesh_vertex_normal_accumulator_core mvna_checker u_mvna_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .zero_normal (zero_normal)
);

`default_nettype wire

@@ tb/mesh_vertex_normal_accumulator_core_test.sv @@
// ---------------------------------------------------------------------------
// Mesh vertex normal accumulator core test
// Drives vertex writes, index streams in list and strip form, restarts and
// normal reads with random gaps and output stalls. A local model of the
// position table, the saturating normal sums and the normalization predicts
// every read item, and the items that come out are compared field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_normal_accumulator_core_test;
    import mvna_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  VERTS       = 4096;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  SETTLE      = 200;
    localparam logic MODE_LIST  = 1'b0;
    localparam logic MODE_STRIP = 1'b1;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic                     zn;
    } normal_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic                     cfg_wr_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               cmd;
    logic [ADDR_W-1:0]        vertex_addr;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [ADDR_W-1:0]        index_value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     zero_normal;

    // Model state.
    longint   vert_pos [VERTS][3];
    longint   sum_x [VERTS];
    longint   sum_y [VERTS];
    longint   sum_z [VERTS];
    int       held_a;
    int       held_b;
    int       held_count;
    logic     odd_face;
    logic     strip_mode;

    normal_t  pending_normals [$];
    bit       written [VERTS];
    int       written_list [$];
    int       vertex_pool [$];
    int       errors;
    int       cycles;
    bit       quiet;

    mesh_vertex_normal_accumulator_core #(.MAX_VERTS(VERTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .vertex_addr(vertex_addr),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .index_value(index_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .zero_normal(zero_normal)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint sat_add(longint a, longint b);
        longint hi;
        longint lo;
        hi = 64'h7FFF_FFFF_FFFF_FFFF;
        lo = 64'h8000_0000_0000_0000;
        if (b > 0 && a > hi - b)
            return hi;
        if (b < 0 && a < lo - b)
            return lo;
        return a + b;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic void accumulate_face(int i0, int i1, int i2);
        longint e1 [3];
        longint e2 [3];
        longint n [3];
        int     v [3];
        v[0] = i0; v[1] = i1; v[2] = i2;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = vert_pos[i0][k] - vert_pos[i1][k];
            e2[k] = vert_pos[i0][k] - vert_pos[i2][k];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int k = 0; k < 3; k++)
        begin
            sum_x[v[k]] = sat_add(sum_x[v[k]], n[0]);
            sum_y[v[k]] = sat_add(sum_y[v[k]], n[1]);
            sum_z[v[k]] = sat_add(sum_z[v[k]], n[2]);
        end
    endfunction

    function automatic normal_t unit_normal(int addr);
        longint          s [3];
        longint unsigned m [3];
        longint unsigned r [3];
        longint unsigned mx;
        longint unsigned len;
        longint unsigned q;
        logic [63:0]     val;
        int              sh;
        normal_t         res;
        res = '0;
        s[0] = sum_x[addr]; s[1] = sum_y[addr]; s[2] = sum_z[addr];
        mx = 0;
        for (int k = 0; k < 3; k++)
        begin
            m[k] = (s[k] < 0) ? 64'd0 - 64'(s[k]) : 64'(s[k]);
            if (m[k] > mx)
                mx = m[k];
        end
        if (mx == 0)
        begin
            res.zn = 1'b1;
            return res;
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30))
            sh++;
        for (int k = 0; k < 3; k++)
            r[k] = m[k] >> sh;
        len = int_sqrt(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]);
        for (int k = 0; k < 3; k++)
        begin
            q = (r[k] * 16384 + (len >> 1)) / len;
            if (q > 16384)
                q = 16384;
            val = (s[k] < 0) ? 64'd0 - q : q;
            case (k)
                0: res.nx = val[15:0];
                1: res.ny = val[15:0];
                default: res.nz = val[15:0];
            endcase
        end
        return res;
    endfunction

    // Applies one accepted item to the model.
    function automatic void predict_item(logic [1:0] c, int addr, longint px, longint py,
                                         longint pz, int idx);
        case (c)
            CMD_WRITE:
            begin
                vert_pos[addr][0] = px;
                vert_pos[addr][1] = py;
                vert_pos[addr][2] = pz;
                sum_x[addr] = 0; sum_y[addr] = 0; sum_z[addr] = 0;
            end
            CMD_PUSH:
            begin
                if (held_count == 0)
                begin
                    held_a = idx;
                    held_count = 1;
                end
                else if (held_count == 1)
                begin
                    held_b = idx;
                    held_count = 2;
                end
                else if (!strip_mode)
                begin
                    accumulate_face(held_a, held_b, idx);
                    held_count = 0;
                end
                else
                begin
                    if (odd_face)
                        accumulate_face(held_b, held_a, idx);
                    else
                        accumulate_face(held_a, held_b, idx);
                    held_a = held_b;
                    held_b = idx;
                    odd_face = ~odd_face;
                end
            end
            CMD_READ:
                pending_normals.push_back(unit_normal(addr));
            default:
            begin
                held_count = 0;
                odd_face = 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** mesh_vertex_normal_accumulator_core: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            predict_item(cmd, vertex_addr, pos_x, pos_y, pos_z, index_value);
    end

    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_normals.size() == 0)
            begin
                $error("normal item with none expected");
                errors++;
            end
            else
            begin
                want = pending_normals.pop_front();
                if (normal_x !== want.nx)
                begin
                    $error("normal_x expected %0d got %0d", want.nx, normal_x);
                    errors++;
                end
                if (normal_y !== want.ny)
                begin
                    $error("normal_y expected %0d got %0d", want.ny, normal_y);
                    errors++;
                end
                if (normal_z !== want.nz)
                begin
                    $error("normal_z expected %0d got %0d", want.nz, normal_z);
                    errors++;
                end
                if (zero_normal !== want.zn)
                begin
                    $error("zero_normal expected %0d got %0d", want.zn, zero_normal);
                    errors++;
                end
            end
        end
    end

    // Receiver: stalls a random number of cycles before each item.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 13);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    task automatic send_item(logic [1:0] c, int addr, int px, int py, int pz, int idx);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        vertex_addr <= addr[ADDR_W-1:0];
        pos_x       <= px[POS_W-1:0];
        pos_y       <= py[POS_W-1:0];
        pos_z       <= pz[POS_W-1:0];
        index_value <= idx[ADDR_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_vertex(int addr, int px, int py, int pz);
        if (!written[addr])
        begin
            written[addr] = 1'b1;
            written_list.push_back(addr);
        end
        send_item(CMD_WRITE, addr, px, py, pz, $urandom);
    endtask

    task automatic push_index(int idx);
        send_item(CMD_PUSH, $urandom, $urandom, $urandom, $urandom, idx);
    endtask

    task automatic read_normal(int addr);
        send_item(CMD_READ, addr, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic restart_stream();
        send_item(CMD_RESTART, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Waits until every read has returned, then lets the core settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_mode(logic mode);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        strip_mode = mode;
    endtask

    task automatic test_list_directed();
        write_vertex(0, -524288, -524288, -524288);
        write_vertex(1, 524287, -524288, 0);
        write_vertex(4095, -524288, 524287, 524287);
        write_vertex(3, 65536, 0, 0);
        write_vertex(4, 0, 65536, 0);
        push_index(0);
        push_index(1);
        push_index(4095);
        read_normal(0);
        read_normal(1);
        read_normal(4095);
        // A face with a repeated vertex adds a zero normal.
        push_index(3);
        push_index(3);
        push_index(4);
        read_normal(3);
        // Never written, so its sum is still the cleared value.
        read_normal(2048);
        // Restart drops a half-built face.
        push_index(1);
        restart_stream();
        push_index(3);
        push_index(4);
        push_index(0);
        read_normal(4);
    endtask

    task automatic test_strip_directed();
        set_mode(MODE_STRIP);
        push_index(0);
        push_index(1);
        push_index(3);
        push_index(4);
        push_index(4095);
        read_normal(3);
        read_normal(4);
        // Leave two indices held across a change back to list form.
        restart_stream();
        push_index(4);
        push_index(0);
        set_mode(MODE_LIST);
        push_index(1);
        read_normal(0);
    endtask

    task automatic random_phase(int count);
        int sel;
        int addr;
        for (int n = 0; n < count; n++)
        begin
            if ((n % 60) == 0)
                quiet = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 15 || written_list.size() < 3)
            begin
                addr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, VERTS - 1)
                       : vertex_pool[$urandom_range(0, vertex_pool.size() - 1)];
                write_vertex(addr, $urandom, $urandom, $urandom);
            end
            else if (sel < 75)
                push_index(written_list[$urandom_range(0, written_list.size() - 1)]);
            else if (sel < 96)
            begin
                addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, VERTS - 1)
                       : written_list[$urandom_range(0, written_list.size() - 1)];
                read_normal(addr);
            end
            else
                restart_stream();
        end
        quiet = 1'b0;
    endtask

    task automatic test_random();
        for (int k = 0; k < 24; k++)
            vertex_pool.push_back($urandom_range(0, VERTS - 1));
        random_phase(250);
        set_mode(MODE_STRIP);
        random_phase(250);
        // The sender holds off until every read has come back.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        random_phase(250);
        set_mode(MODE_LIST);
        random_phase(150);
        set_mode(MODE_STRIP);
        random_phase(120);
    endtask

    initial
    begin
        errors      = 0;
        cycles      = 0;
        quiet       = 1'b0;
        strip_mode  = MODE_LIST;
        held_a      = 0;
        held_b      = 0;
        held_count  = 0;
        odd_face    = 1'b0;
        for (int v = 0; v < VERTS; v++)
        begin
            sum_x[v] = 0; sum_y[v] = 0; sum_z[v] = 0;
            vert_pos[v][0] = 0; vert_pos[v][1] = 0; vert_pos[v][2] = 0;
        end
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_WRITE;
        vertex_addr = '0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        index_value = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_mode(MODE_LIST);
        test_list_directed();
        test_strip_directed();
        test_random();
        drain();

        if (errors == 0)
            $display("** mesh_vertex_normal_accumulator_core: PASSED **");
        else
            $display("** mesh_vertex_normal_accumulator_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
